// ----- src/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types, constants and elaboration-time helpers for the rectangular /
// polar CORDIC converter.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int ANGLE_W = 16;               // binary angle, 2^16 = full turn
  localparam int GUARD   = 16;               // fraction bits in the datapath
  localparam int ZACC_W  = ANGLE_W + GUARD;  // angle accumulator, 2^32 = turn
  localparam int KINV_W  = 30;               // inverse gain, Q30
  localparam int ATAN_N  = 32;

  // round(atan(2^-i) * 2^32 / (2*pi))
  localparam logic [ZACC_W-1:0] ATAN_TAB [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  typedef enum logic {
    REQ_TO_POLAR = 1'b0,
    REQ_TO_CART  = 1'b1
  } req_e;

  // control that travels with each beat down the pipeline
  typedef struct packed {
    logic valid;
    req_e req;
    logic zero;   // to-polar of the zero vector
  } rpc_ctl_t;

  // Inverse CORDIC gain in Q30: round(2^60 / floor(sqrt(P))), where P is
  // prod(1 + 4^-i) in Q60 with each step truncated. Elaboration only.
  function automatic logic [KINV_W-1:0] inv_gain(input int stages);
    logic [63:0] p;
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bv;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] q;
    int          i;
    p = 64'h1 << 60;
    for (i = 0; i < stages; i++) begin
      p = p + (p >> (2 * i));
    end
    // integer square root
    n   = p;
    res = '0;
    bv  = 64'h1 << 62;
    for (i = 0; i < 32; i++) begin
      if (bv > n) begin
        bv = bv >> 2;
      end
    end
    for (i = 0; i < 32; i++) begin
      if (bv != '0) begin
        if (n >= res + bv) begin
          n   = n - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
        bv = bv >> 2;
      end
    end
    if (res == '0) begin
      res = 64'd1;
    end
    // restoring division, rounded
    num = (64'h1 << 60) + (res >> 1);
    rem = '0;
    q   = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= res) begin
        rem  = rem - res;
        q[i] = 1'b1;
      end
    end
    return q[KINV_W-1:0];
  endfunction

endpackage

// ----- src/rpc_gain_mul.sv -----
// ----------------------------------------------------------------------------
// rpc_gain_mul
// Two-stage constant gain multiplier: floor(a * KINV / 2^SHIFT). The operand
// is split in two halves; partial products are registered, then summed.
// ----------------------------------------------------------------------------
module rpc_gain_mul
  import rpc_pkg::*;
#(
  parameter int                IN_W   = 16,
  parameter int                SHIFT  = 14,
  parameter logic [KINV_W-1:0] KINV   = '0,
  parameter int                SIDE_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  rpc_ctl_t                     ctl_i,
  input  logic [IN_W-1:0]              a_i,
  input  logic [SIDE_W-1:0]            side_i,
  output rpc_ctl_t                     ctl_o,
  output logic [IN_W+KINV_W-SHIFT-1:0] p_o,
  output logic [SIDE_W-1:0]            side_o
);

  localparam int LO_W = IN_W / 2;
  localparam int HI_W = IN_W - LO_W;
  localparam int PW   = IN_W + KINV_W;

  logic [LO_W+KINV_W-1:0] lo_d, lo_q;
  logic [HI_W+KINV_W-1:0] hi_d, hi_q;
  logic [PW-1:0]          sum;
  rpc_ctl_t               ctl_a_q, ctl_b_q;
  logic [SIDE_W-1:0]      side_a_q, side_b_q;
  logic [PW-SHIFT-1:0]    p_q;

  assign lo_d = (LO_W+KINV_W)'(a_i[LO_W-1:0]) * (LO_W+KINV_W)'(KINV);
  assign hi_d = (HI_W+KINV_W)'(a_i[IN_W-1:LO_W]) * (HI_W+KINV_W)'(KINV);
  assign sum  = (PW'(hi_q) << LO_W) + PW'(lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      side_a_q <= side_i;
      p_q      <= sum[PW-1:SHIFT];
      side_b_q <= side_a_q;
    end
  end

  assign ctl_o  = ctl_b_q;
  assign p_o    = p_q;
  assign side_o = side_b_q;

endmodule

// ----- src/rpc_cordic_stage.sv -----
// ----------------------------------------------------------------------------
// rpc_cordic_stage
// One registered CORDIC micro-rotation. Vectoring (to-polar) steers on the
// sign of y, rotation (to-cartesian) on the sign of the residual angle.
// ----------------------------------------------------------------------------
module rpc_cordic_stage
  import rpc_pkg::*;
#(
  parameter int DW     = 35,
  parameter int STAGE  = 0,
  parameter int META_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  rpc_ctl_t             ctl_i,
  input  logic signed [DW-1:0] x_i,
  input  logic signed [DW-1:0] y_i,
  input  logic [ZACC_W-1:0]    z_i,
  input  logic [META_W-1:0]    meta_i,
  output rpc_ctl_t             ctl_o,
  output logic signed [DW-1:0] x_o,
  output logic signed [DW-1:0] y_o,
  output logic [ZACC_W-1:0]    z_o,
  output logic [META_W-1:0]    meta_o
);

  logic signed [DW-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic [ZACC_W-1:0]    z_d, z_q;
  logic [META_W-1:0]    meta_q;
  rpc_ctl_t             ctl_q;
  logic                 up;

  assign dx = x_i >>> STAGE;
  assign dy = y_i >>> STAGE;
  // up: rotate clockwise, angle accumulator grows
  assign up = (ctl_i.req == REQ_TO_POLAR) ? ~y_i[DW-1] : z_i[ZACC_W-1];

  always_comb begin
    if (up) begin
      x_d = x_i + dy;
      y_d = y_i - dx;
      z_d = z_i + ATAN_TAB[STAGE];
    end else begin
      x_d = x_i - dy;
      y_d = y_i + dx;
      z_d = z_i - ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      meta_q <= meta_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign meta_o = meta_q;

endmodule

// ----- src/rect_polar_converter_top.sv -----
// Registers in order: input, gain prescale, CORDIC stages, gain postscale, output.
// One beat per cycle unless stalled; every stage is a register on a global enable.
// Input stall asserts only while the output register holds a beat that is stalled.
// Reset (rst_ni low, async) empties the pipeline; no state survives between beats.
// ----------------------------------------------------------------------------
// rect_polar_converter_top
// Fixed-point CORDIC converter between rectangular and polar form. Both
// request types share one unrolled pipeline: input conditioning, gain
// prescale, ITERATIONS micro-rotations, gain postscale and output select.
// ----------------------------------------------------------------------------
module rect_polar_converter_top
  import rpc_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int ITERATIONS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic                          req_type_i,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  input  logic [COORD_WIDTH-1:0]        length_in_i,
  input  logic [ANGLE_W-1:0]            angle_in_i,
  // result channel
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic signed [COORD_WIDTH-1:0] out_x_o,
  output logic signed [COORD_WIDTH-1:0] out_y_o,
  output logic [COORD_WIDTH-1:0]        out_length_o,
  output logic [ANGLE_W-1:0]            out_angle_o
);

  localparam int W      = COORD_WIDTH;
  // datapath: coordinate + guard fraction + headroom for CORDIC gain and sqrt(2)
  localparam int DW     = W + GUARD + 3;
  localparam int META_W = 3 * W + ANGLE_W;
  localparam logic [KINV_W-1:0] KINV = inv_gain(ITERATIONS);

  // prescale: floor(len * 2^GUARD * K / 2^30) = floor(len * K / 2^(30-GUARD))
  localparam int PRE_SHIFT  = KINV_W - GUARD;
  localparam int PRE_P_W    = W + KINV_W - PRE_SHIFT;
  localparam int PRE_SIDE_W = 1 + 2 * (W + 1) + ZACC_W + META_W;
  // postscale: floor(x * K / 2^30) on the non-negative vectoring x
  localparam int POST_IN_W   = DW - 1;
  localparam int POST_P_W    = POST_IN_W;
  localparam int POST_SIDE_W = 2 * W + ANGLE_W + META_W;
  localparam int SIGN_EXT    = DW - (W + 1) - GUARD;

  // --------------------------------------------------------------------------
  // Pipeline enable: everything advances unless the output beat is held.
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en      = ~(out_valid_q & stall_i);
  assign stall_o = out_valid_q & stall_i;

  // --------------------------------------------------------------------------
  // Input conditioning
  //   to-polar: left half plane is turned by a half turn (negate x and y,
  //             start the angle at half a turn); zero vector is flagged.
  //   to-cartesian: angle beyond a quarter turn either way is folded by a
  //             half turn (flip the angle MSB) and the start vector negated.
  // --------------------------------------------------------------------------
  logic signed [W:0]   sx, sy, xa_d, ya_d;
  logic [ZACC_W-1:0]   t_ang, z0_d;
  logic                neg_x, fold, neg_d;
  rpc_ctl_t            ctl_d;

  assign sx    = {coord_x_i[W-1], coord_x_i};
  assign sy    = {coord_y_i[W-1], coord_y_i};
  assign neg_x = coord_x_i[W-1];
  assign xa_d  = neg_x ? -sx : sx;
  assign ya_d  = neg_x ? -sy : sy;

  assign t_ang = {angle_in_i, {GUARD{1'b0}}};
  assign fold  = ((t_ang[ZACC_W-1:ZACC_W-2] == 2'b01) && (t_ang[ZACC_W-3:0] != '0)) ||
                 (t_ang[ZACC_W-1:ZACC_W-2] == 2'b10);

  always_comb begin
    ctl_d.valid = valid_i;
    ctl_d.req   = req_e'(req_type_i);
    ctl_d.zero  = (coord_x_i == '0) && (coord_y_i == '0);
    if (ctl_d.req == REQ_TO_CART) begin
      z0_d  = fold ? {~t_ang[ZACC_W-1], t_ang[ZACC_W-2:0]} : t_ang;
      neg_d = fold;
    end else begin
      z0_d  = neg_x ? {1'b1, {(ZACC_W-1){1'b0}}} : '0;
      neg_d = 1'b0;
    end
  end

  rpc_ctl_t          s0_ctl_q;
  logic signed [W:0] s0_xa_q, s0_ya_q;
  logic [ZACC_W-1:0] s0_z_q;
  logic              s0_neg_q;
  logic [W-1:0]      s0_len_q;
  logic [META_W-1:0] s0_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctl_q <= '0;
    end else if (en) begin
      s0_ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_xa_q   <= xa_d;
      s0_ya_q   <= ya_d;
      s0_z_q    <= z0_d;
      s0_neg_q  <= neg_d;
      s0_len_q  <= length_in_i;
      // pass-through fields ride along to the output select
      s0_meta_q <= {coord_x_i, coord_y_i, length_in_i, angle_in_i};
    end
  end

  // --------------------------------------------------------------------------
  // Gain prescale for to-cartesian (2 stages)
  // --------------------------------------------------------------------------
  rpc_ctl_t              pre_ctl;
  logic [PRE_P_W-1:0]    pre_p;
  logic [PRE_SIDE_W-1:0] pre_side;
  logic                  pre_neg;
  logic signed [W:0]     pre_xa, pre_ya;
  logic [ZACC_W-1:0]     pre_z;
  logic [META_W-1:0]     pre_meta;

  rpc_gain_mul #(
    .IN_W   (W),
    .SHIFT  (PRE_SHIFT),
    .KINV   (KINV),
    .SIDE_W (PRE_SIDE_W)
  ) u_pre_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (s0_ctl_q),
    .a_i    (s0_len_q),
    .side_i ({s0_neg_q, s0_xa_q, s0_ya_q, s0_z_q, s0_meta_q}),
    .ctl_o  (pre_ctl),
    .p_o    (pre_p),
    .side_o (pre_side)
  );

  assign {pre_neg, pre_xa, pre_ya, pre_z, pre_meta} = pre_side;

  // --------------------------------------------------------------------------
  // CORDIC chain, one micro-rotation per stage
  // --------------------------------------------------------------------------
  rpc_ctl_t             c_ctl  [ITERATIONS+1];
  logic signed [DW-1:0] c_x    [ITERATIONS+1];
  logic signed [DW-1:0] c_y    [ITERATIONS+1];
  logic [ZACC_W-1:0]    c_z    [ITERATIONS+1];
  logic [META_W-1:0]    c_meta [ITERATIONS+1];
  logic signed [DW-1:0] pre_mag, pol_x0, pol_y0;

  assign pre_mag = DW'(pre_p);
  assign pol_x0  = {{SIGN_EXT{pre_xa[W]}}, pre_xa, {GUARD{1'b0}}};
  assign pol_y0  = {{SIGN_EXT{pre_ya[W]}}, pre_ya, {GUARD{1'b0}}};

  assign c_ctl[0]  = pre_ctl;
  assign c_x[0]    = (pre_ctl.req == REQ_TO_CART) ? (pre_neg ? -pre_mag : pre_mag) : pol_x0;
  assign c_y[0]    = (pre_ctl.req == REQ_TO_CART) ? '0 : pol_y0;
  assign c_z[0]    = pre_z;
  assign c_meta[0] = pre_meta;

  for (genvar g = 0; g < ITERATIONS; g++) begin : g_stage
    rpc_cordic_stage #(
      .DW     (DW),
      .STAGE  (g),
      .META_W (META_W)
    ) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (c_ctl[g]),
      .x_i    (c_x[g]),
      .y_i    (c_y[g]),
      .z_i    (c_z[g]),
      .meta_i (c_meta[g]),
      .ctl_o  (c_ctl[g+1]),
      .x_o    (c_x[g+1]),
      .y_o    (c_y[g+1]),
      .z_o    (c_z[g+1]),
      .meta_o (c_meta[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Post-chain: round x/y (to-cartesian) and the angle (to-polar) while the
  // vectoring x goes through the gain postscale (2 stages).
  // --------------------------------------------------------------------------
  // remove guard bits rounding half up, then clamp to the signed range
  function automatic logic [W-1:0] round_sat(input logic signed [DW-1:0] v);
    logic [DW:0]       s;
    logic [DW-GUARD:0] r;
    s = {v[DW-1], v} + (DW+1)'(2 ** (GUARD - 1));
    r = s[DW:GUARD];
    if ((r[DW-GUARD:W-1] == '0) || (r[DW-GUARD:W-1] == '1)) begin
      return r[W-1:0];
    end else if (r[DW-GUARD]) begin
      return {1'b1, {(W-1){1'b0}}};
    end else begin
      return {1'b0, {(W-1){1'b1}}};
    end
  endfunction

  logic [W-1:0]       post_rx, post_ry;
  logic [ZACC_W-1:0]  post_ang_sum;
  logic [ANGLE_W-1:0] post_ang;

  assign post_rx      = round_sat(c_x[ITERATIONS]);
  assign post_ry      = round_sat(c_y[ITERATIONS]);
  assign post_ang_sum = c_z[ITERATIONS] + ZACC_W'(2 ** (GUARD - 1));
  assign post_ang     = post_ang_sum[ZACC_W-1:GUARD];

  rpc_ctl_t               po_ctl;
  logic [POST_P_W-1:0]    po_p;
  logic [POST_SIDE_W-1:0] po_side;
  logic [W-1:0]           po_rx, po_ry;
  logic [ANGLE_W-1:0]     po_ang;
  logic [W-1:0]           m_x, m_y, m_len;
  logic [ANGLE_W-1:0]     m_ang;

  rpc_gain_mul #(
    .IN_W   (POST_IN_W),
    .SHIFT  (KINV_W),
    .KINV   (KINV),
    .SIDE_W (POST_SIDE_W)
  ) u_post_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctl_i  (c_ctl[ITERATIONS]),
    .a_i    (c_x[ITERATIONS][DW-2:0]),
    .side_i ({post_rx, post_ry, post_ang, c_meta[ITERATIONS]}),
    .ctl_o  (po_ctl),
    .p_o    (po_p),
    .side_o (po_side)
  );

  assign {po_rx, po_ry, po_ang, m_x, m_y, m_len, m_ang} = po_side;

  // length: drop guard bits rounding half up, clamp to all ones
  logic [DW-1:0]       len_sum;
  logic [DW-GUARD-1:0] len_r;
  logic [W-1:0]        len_sat;

  assign len_sum = {1'b0, po_p} + DW'(2 ** (GUARD - 1));
  assign len_r   = len_sum[DW-1:GUARD];
  assign len_sat = (|len_r[DW-GUARD-1:W]) ? '1 : len_r[W-1:0];

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [W-1:0]       out_x_q, out_y_q, out_len_q;
  logic [ANGLE_W-1:0] out_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= po_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && po_ctl.valid) begin
      if (po_ctl.req == REQ_TO_CART) begin
        out_x_q   <= po_rx;
        out_y_q   <= po_ry;
        out_len_q <= m_len;
        out_ang_q <= m_ang;
      end else begin
        out_x_q   <= m_x;
        out_y_q   <= m_y;
        out_len_q <= po_ctl.zero ? '0 : len_sat;
        out_ang_q <= po_ctl.zero ? '0 : po_ang;
      end
    end
  end

  assign valid_o      = out_valid_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign out_length_o = out_len_q;
  assign out_angle_o  = out_ang_q;

endmodule

// ----- src/rpc_checker.sv -----
// ----------------------------------------------------------------------------
// rpc_checker
// Port-level checks: backpressure source, held beats, zero-vector result, and
// pass-through fields at the fixed pipeline latency after an unstalled run.
// ----------------------------------------------------------------------------
module rpc_checker
  import rpc_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int ITERATIONS  = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          valid_i,
  input logic                          stall_o,
  input logic                          req_type_i,
  input logic signed [COORD_WIDTH-1:0] coord_x_i,
  input logic signed [COORD_WIDTH-1:0] coord_y_i,
  input logic [COORD_WIDTH-1:0]        length_in_i,
  input logic [ANGLE_W-1:0]            angle_in_i,
  input logic                          valid_o,
  input logic                          stall_i,
  input logic signed [COORD_WIDTH-1:0] out_x_o,
  input logic signed [COORD_WIDTH-1:0] out_y_o,
  input logic [COORD_WIDTH-1:0]        out_length_o,
  input logic [ANGLE_W-1:0]            out_angle_o
);

  localparam int LAT   = ITERATIONS + 6;
  localparam int RUN_W = $clog2(LAT + 1);

  // consecutive cycles with the input side not stalled, saturating at LAT
  logic [RUN_W-1:0] run_q;
  logic             clean;
  logic             acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (stall_o) begin
      run_q <= '0;
    end else if (run_q != RUN_W'(LAT)) begin
      run_q <= run_q + RUN_W'(1);
    end
  end

  assign clean = (run_q == RUN_W'(LAT));
  assign acc   = valid_i && !stall_o;

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o == (valid_o && stall_i))
    else $error("input stall not caused by a held output beat");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(out_x_o) && $stable(out_y_o) &&
                           $stable(out_length_o) && $stable(out_angle_o))
    else $error("stalled output beat changed");

  a_polar_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clean && $past(acc && (req_type_i == REQ_TO_POLAR), LAT) |->
      valid_o && (out_x_o == $past(coord_x_i, LAT)) && (out_y_o == $past(coord_y_i, LAT)))
    else $error("to-polar beat lost or coordinates not passed through");

  a_cart_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clean && $past(acc && (req_type_i == REQ_TO_CART), LAT) |->
      valid_o && (out_length_o == $past(length_in_i, LAT)) &&
      (out_angle_o == $past(angle_in_i, LAT)))
    else $error("to-cartesian beat lost or length/angle not passed through");

  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clean && $past(acc && (req_type_i == REQ_TO_POLAR) &&
                   (coord_x_i == '0) && (coord_y_i == '0), LAT) |->
      (out_length_o == '0) && (out_angle_o == '0))
    else $error("zero vector did not give zero length and angle");

endmodule

bind rect_polar_converter_top rpc_checker #(
  .COORD_WIDTH (COORD_WIDTH),
  .ITERATIONS  (ITERATIONS)
) u_rpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (valid_i),
  .stall_o      (stall_o),
  .req_type_i   (req_type_i),
  .coord_x_i    (coord_x_i),
  .coord_y_i    (coord_y_i),
  .length_in_i  (length_in_i),
  .angle_in_i   (angle_in_i),
  .valid_o      (valid_o),
  .stall_i      (stall_i),
  .out_x_o      (out_x_o),
  .out_y_o      (out_y_o),
  .out_length_o (out_length_o),
  .out_angle_o  (out_angle_o)
);

// ----- bench/rect_polar_checker.sv -----
// ----------------------------------------------------------------------------
// rect_polar_checker
// Watches the request and result channels of the converter. For each
// accepted request beat it computes the expected result with a fixed-point
// CORDIC of its own. It compares each accepted result beat, field by field,
// with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module rect_polar_checker
  import rpc_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int ITERATIONS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          req_valid_i,
  input  logic                          req_stall_i,
  input  logic                          req_type_i,
  input  logic signed [COORD_WIDTH-1:0] req_x_i,
  input  logic signed [COORD_WIDTH-1:0] req_y_i,
  input  logic [COORD_WIDTH-1:0]        req_length_i,
  input  logic [ANGLE_W-1:0]            req_angle_i,
  // result channel
  input  logic                          res_valid_i,
  input  logic                          res_stall_i,
  input  logic [COORD_WIDTH-1:0]        res_x_i,
  input  logic [COORD_WIDTH-1:0]        res_y_i,
  input  logic [COORD_WIDTH-1:0]        res_length_i,
  input  logic [ANGLE_W-1:0]            res_angle_i,
  // status for the bench top
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            checked_o
);

  localparam int FRAC        = 16;  // guard bits below the coordinate LSB
  localparam int STAGES      = (ITERATIONS > 32) ? 32 : ITERATIONS;
  localparam int MAX_REPORTS = 30;

  localparam longint          COORD_MAX    = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
  localparam longint unsigned LEN_MAX      = (64'd1 << COORD_WIDTH) - 1;
  localparam longint          QUARTER_TURN = 64'sd1 <<< 30;
  localparam longint          HALF_TURN    = 64'sd1 <<< 31;

  // atan(2^-i) in units where 2^32 is a full turn
  localparam longint ARCTAN [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838,  5340245,   2670163,   1335087,  667544,   333772,
    166886,    83443,     41722,     20861,    10430,    5215,
    2608,      1304,      652,       326,      163,      81,
    41,        20,        10,        5,        3,        1,
    1,         0
  };

  typedef struct {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] length;
    logic [ANGLE_W-1:0]     angle;
  } conv_result_t;

  conv_result_t    outstanding_q[$];
  longint unsigned inv_gain_q30;
  int              fails;
  int              reports;
  int              checked;

  // inverse CORDIC gain, Q30
  initial begin : gain_setup
    longint unsigned prod;
    longint unsigned rest;
    longint unsigned root;
    longint unsigned bitv;
    int              i;
    prod = 64'd1 << 60;
    for (i = 0; i < STAGES; i++) begin
      prod = prod + (prod >> (2 * i));
    end
    rest = prod;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rest) begin
      bitv = bitv >> 2;
    end
    while (bitv != 0) begin
      if (rest >= root + bitv) begin
        rest = rest - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (root == 0) begin
      root = 1;
    end
    inv_gain_q30 = ((64'd1 << 60) + root / 2) / root;
  end

  // floor(v * K / 2^30), exact
  function automatic longint unsigned scale_by_gain(input longint unsigned v);
    logic [127:0] p;
    p = {64'd0, v} * {64'd0, inv_gain_q30};
    return p[93:30];
  endfunction

  // drop guard bits rounding half up, clamp to the signed coordinate range
  function automatic logic [COORD_WIDTH-1:0] round_to_coord(input longint v);
    longint r;
    r = (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    if (r > COORD_MAX) begin
      r = COORD_MAX;
    end
    if (r < -COORD_MAX - 1) begin
      r = -COORD_MAX - 1;
    end
    return r[COORD_WIDTH-1:0];
  endfunction

  function automatic conv_result_t convert_beat(
    input logic                          req,
    input logic signed [COORD_WIDTH-1:0] cx,
    input logic signed [COORD_WIDTH-1:0] cy,
    input logic [COORD_WIDTH-1:0]        len_in,
    input logic [ANGLE_W-1:0]            ang_in
  );
    conv_result_t       r;
    longint             x;
    longint             y;
    longint             z;
    longint             dx;
    longint             dy;
    longint unsigned    mag;
    logic [31:0]        zacc;
    logic [31:0]        zround;
    logic signed [31:0] target;
    logic               flip;
    int                 i;
    if (req == REQ_TO_POLAR) begin
      r.x      = cx;
      r.y      = cy;
      r.length = '0;
      r.angle  = '0;
      if (cx != '0 || cy != '0) begin
        x    = longint'(cx);
        y    = longint'(cy);
        zacc = '0;
        if (x < 0) begin
          // left half plane: turn by a half turn first
          x    = -x;
          y    = -y;
          zacc = 32'h8000_0000;
        end
        x = x <<< FRAC;
        y = y <<< FRAC;
        for (i = 0; i < STAGES; i++) begin
          dx = x >>> i;
          dy = y >>> i;
          if (y >= 0) begin
            x    = x + dy;
            y    = y - dx;
            zacc = zacc + 32'(ARCTAN[i]);
          end else begin
            x    = x - dy;
            y    = y + dx;
            zacc = zacc - 32'(ARCTAN[i]);
          end
        end
        mag = (scale_by_gain(x) + (64'd1 << (FRAC - 1))) >> FRAC;
        if (mag > LEN_MAX) begin
          mag = LEN_MAX;
        end
        r.length = mag[COORD_WIDTH-1:0];
        zround   = zacc + (32'd1 << (31 - ANGLE_W));
        r.angle  = zround[31 -: ANGLE_W];
      end
    end else begin
      target = {ang_in, {(32 - ANGLE_W){1'b0}}};
      z      = longint'(target);
      flip   = 1'b0;
      // beyond a quarter turn: start from the negated vector
      if (z > QUARTER_TURN) begin
        z    = z - HALF_TURN;
        flip = 1'b1;
      end else if (z < -QUARTER_TURN) begin
        z    = z + HALF_TURN;
        flip = 1'b1;
      end
      mag = 64'(len_in);
      x   = scale_by_gain(mag << FRAC);
      if (flip) begin
        x = -x;
      end
      y = 0;
      for (i = 0; i < STAGES; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (z >= 0) begin
          x = x - dy;
          y = y + dx;
          z = z - ARCTAN[i];
        end else begin
          x = x + dy;
          y = y - dx;
          z = z + ARCTAN[i];
        end
      end
      r.x      = round_to_coord(x);
      r.y      = round_to_coord(y);
      r.length = len_in;
      r.angle  = ang_in;
    end
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want,
                            input logic [31:0] got);
    fails++;
    if (reports < MAX_REPORTS) begin
      reports++;
      $display("%0t: %s expected %h got %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    conv_result_t want;
    if (rst_ni) begin
      if ($isunknown({req_stall_i, res_valid_i})) begin
        flag_field("handshake", '0, {30'd0, req_stall_i, res_valid_i});
      end
      if (req_valid_i && !req_stall_i) begin
        outstanding_q.push_back(convert_beat(req_type_i, req_x_i, req_y_i,
                                             req_length_i, req_angle_i));
      end
      if (res_valid_i && !res_stall_i) begin
        checked++;
        if (outstanding_q.size() == 0) begin
          fails++;
          if (reports < MAX_REPORTS) begin
            reports++;
            $display("%0t: result beat expected none got x %h y %h len %h ang %h",
                     $time, res_x_i, res_y_i, res_length_i, res_angle_i);
          end
        end else begin
          want = outstanding_q.pop_front();
          if (res_x_i !== want.x) begin
            flag_field("out_x", 32'(want.x), 32'(res_x_i));
          end
          if (res_y_i !== want.y) begin
            flag_field("out_y", 32'(want.y), 32'(res_y_i));
          end
          if (res_length_i !== want.length) begin
            flag_field("out_length", 32'(want.length), 32'(res_length_i));
          end
          if (res_angle_i !== want.angle) begin
            flag_field("out_angle", 32'(want.angle), 32'(res_angle_i));
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= outstanding_q.size();
    checked_o    <= checked;
  end

endmodule

// ----- bench/tb_rect_polar_converter_top.sv -----
// ----------------------------------------------------------------------------
// tb_rect_polar_converter_top
// Bench for the rectangular / polar CORDIC converter. It sends directed
// corner beats and then random ones of both request types, with random gaps
// on the request side and random stalls on the result side. A checker beside
// the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_rect_polar_converter_top;
  import rpc_pkg::*;

  localparam int CW           = 16;
  localparam int ITERS        = 16;
  localparam int RANDOM_ITEMS = 1500;
  localparam int DRAIN_CYCLES = 40;       // pipeline is ITERS + 6 deep
  localparam int CYCLE_LIMIT  = 1000000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 valid_i     = 1'b0;
  logic                 stall_o;
  logic                 req_type_i  = 1'b0;
  logic signed [CW-1:0] coord_x_i   = '0;
  logic signed [CW-1:0] coord_y_i   = '0;
  logic [CW-1:0]        length_in_i = '0;
  logic [ANGLE_W-1:0]   angle_in_i  = '0;
  logic                 valid_o;
  logic                 stall_i     = 1'b0;
  logic signed [CW-1:0] out_x_o;
  logic signed [CW-1:0] out_y_o;
  logic [CW-1:0]        out_length_o;
  logic [ANGLE_W-1:0]   out_angle_o;

  int fail_count;
  int pending;
  int checked;
  int cycle_count = 0;
  int polar_sent  = 0;
  int cart_sent   = 0;
  int stall_hold  = 0;
  bit calm_phase  = 1'b0;  // no request gaps and no new stall runs while set

  // 10 time unit clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rect_polar_converter_top #(
    .COORD_WIDTH (CW),
    .ITERATIONS  (ITERS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .req_type_i   (req_type_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .length_in_i  (length_in_i),
    .angle_in_i   (angle_in_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_length_o (out_length_o),
    .out_angle_o  (out_angle_o)
  );

  rect_polar_checker #(
    .COORD_WIDTH (CW),
    .ITERATIONS  (ITERS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (valid_i),
    .req_stall_i  (stall_o),
    .req_type_i   (req_type_i),
    .req_x_i      (coord_x_i),
    .req_y_i      (coord_y_i),
    .req_length_i (length_in_i),
    .req_angle_i  (angle_in_i),
    .res_valid_i  (valid_o),
    .res_stall_i  (stall_i),
    .res_x_i      (out_x_o),
    .res_y_i      (out_y_o),
    .res_length_i (out_length_o),
    .res_angle_i  (out_angle_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_gap(input bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) begin
      return 0;
    end
    if (roll < 85) begin
      return $urandom_range(1, 3);
    end
    if (roll < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Coordinate mix: full range mostly, some near zero, some at the rails.
  function automatic logic [CW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return CW'($urandom_range(0, 32) - 16);
      1: begin
        case ($urandom_range(0, 3))
          0:       return {1'b1, {(CW-1){1'b0}}};  // most negative
          1:       return {1'b0, {(CW-1){1'b1}}};  // most positive
          2:       return '0;
          default: return '1;                     // -1
        endcase
      end
      default: return CW'($urandom);
    endcase
  endfunction

  // Result side: stall in runs of random length. Only stall_i and the run
  // counter change here, each with one nonblocking write per edge.
  always @(posedge clk_i) begin : result_pacing
    int run;
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (calm_phase) begin
      stall_i    <= 1'b0;
      stall_hold <= 8;
    end else if ($urandom_range(0, 1) == 0) begin
      stall_i    <= 1'b0;
      stall_hold <= $urandom_range(0, 7);
    end else begin
      run        = pick_gap(1'b0);
      stall_i    <= (run != 0);
      stall_hold <= (run > 0) ? run - 1 : 0;
    end
  end

  // Watchdog: a hung handshake or lost beat ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // One request beat: optional idle gap, then hold valid and payload until the
  // block takes it. Called right after a rising edge; valid is written once
  // per edge, so back-to-back beats keep it high without a dip.
  task automatic send_request(input req_e req, input logic [CW-1:0] x,
                              input logic [CW-1:0] y, input logic [CW-1:0] len,
                              input logic [ANGLE_W-1:0] ang);
    int gap;
    gap = pick_gap(calm_phase);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i     <= 1'b1;
    req_type_i  <= req;
    coord_x_i   <= x;
    coord_y_i   <= y;
    length_in_i <= len;
    angle_in_i  <= ang;
    @(posedge clk_i);
    while (stall_o) begin
      @(posedge clk_i);
    end
    if (req == REQ_TO_POLAR) begin
      polar_sent++;
    end else begin
      cart_sent++;
    end
  endtask

  initial begin : stimulus
    int                 n;
    logic [CW-1:0]      len;
    logic [ANGLE_W-1:0] ang;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // to-polar corners: zero vector, rails, left half plane, axes, -1
    send_request(REQ_TO_POLAR, 16'h0000, 16'h0000, '0, '0);
    send_request(REQ_TO_POLAR, 16'h7FFF, 16'h0000, '1, '1);
    send_request(REQ_TO_POLAR, 16'h8000, 16'h0000, '0, '0);
    send_request(REQ_TO_POLAR, 16'h0000, 16'h7FFF, '1, '1);
    send_request(REQ_TO_POLAR, 16'h0000, 16'h8000, '0, '0);
    send_request(REQ_TO_POLAR, 16'h8000, 16'h8000, '0, '0);
    send_request(REQ_TO_POLAR, 16'h7FFF, 16'h7FFF, '0, '0);
    send_request(REQ_TO_POLAR, 16'h8000, 16'h7FFF, '0, '0);
    send_request(REQ_TO_POLAR, 16'hFFFF, 16'h0000, '0, '0);
    send_request(REQ_TO_POLAR, 16'h0001, 16'hFFFF, '0, '0);
    send_request(REQ_TO_POLAR, 16'hFFFF, 16'hFFFF, '0, '0);
    send_request(REQ_TO_POLAR, 16'h0000, 16'hFFFF, '0, '0);
    send_request(REQ_TO_POLAR, 16'h0000, 16'h0001, '0, '0);

    // to-cartesian: zero length, saturation at 45 degrees, quadrant edges
    // (exactly a quarter turn stays, one step past folds), half turn
    send_request(REQ_TO_CART, '0, '0, 16'd0,     16'h0000);
    send_request(REQ_TO_CART, '1, '1, 16'd46341, 16'h2000);
    send_request(REQ_TO_CART, '0, '0, 16'd46341, 16'h0000);
    send_request(REQ_TO_CART, '0, '0, 16'd46341, 16'h4000);
    send_request(REQ_TO_CART, '0, '0, 16'd46341, 16'h4001);
    send_request(REQ_TO_CART, '0, '0, 16'd46341, 16'hC000);
    send_request(REQ_TO_CART, '0, '0, 16'd46341, 16'hBFFF);
    send_request(REQ_TO_CART, '0, '0, 16'd46341, 16'h8000);
    send_request(REQ_TO_CART, '0, '0, 16'd46341, 16'hFFFF);
    send_request(REQ_TO_CART, '0, '0, 16'd12345, 16'h7FFF);
    send_request(REQ_TO_CART, '0, '0, 16'd1,     16'h6000);

    // random beats; unused fields carry noise
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        calm_phase <= ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 1) == 0) begin
        send_request(REQ_TO_POLAR, pick_coord(), pick_coord(), CW'($urandom),
                     ANGLE_W'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0:       len = CW'($urandom_range(0, 16));
          1:       len = CW'($urandom_range(46000, 46341));
          default: len = CW'($urandom_range(0, 46341));
        endcase
        if ($urandom_range(0, 7) == 0) begin
          // within one step of a quadrant boundary
          ang = ANGLE_W'($urandom_range(0, 3) * 16384 + $urandom_range(0, 2) - 1);
        end else begin
          ang = ANGLE_W'($urandom);
        end
        send_request(REQ_TO_CART, pick_coord(), pick_coord(), len, ang);
      end
    end
    valid_i <= 1'b0;

    // checker status is registered; let the last push show up first
    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d to-polar and %0d to-cartesian beats, %0d results compared",
             polar_sent, cart_sent, checked);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/rpc_pkg.sv
src/rpc_gain_mul.sv
src/rpc_cordic_stage.sv
src/rect_polar_converter_top.sv
src/rpc_checker.sv
bench/rect_polar_checker.sv
bench/tb_rect_polar_converter_top.sv
